// ===== rtl/irlp_pkg.sv =====
// Shared types and constants for the IPv4 range rule line parser.
// No dependencies; imported by irlp_step and ipv4_range_rule_line_parser.
package irlp_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_TOKEN,
    PH_MID,
    PH_RACK,
    PH_TAIL,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BLANK      = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_BADNET     = 3'd3,
    ST_BADRACK    = 3'd4,
    ST_GARBAGE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FORM_PLAIN,
    FORM_SLASH,
    FORM_DASH,
    FORM_STAR
  } form_e;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_LF    = 8'h0a;
  localparam logic [7:0]  CH_CR    = 8'h0d;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_STAR  = 8'h2a;
  localparam logic [7:0]  CH_DASH  = 8'h2d;
  localparam logic [7:0]  CH_DOT   = 8'h2e;
  localparam logic [7:0]  CH_SLASH = 8'h2f;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;

  localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [7:0]  OCTET_MAX  = 8'd255;
  localparam logic [7:0]  PREFIX_MAX = 8'd32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] rack_number;
  } out_rsp_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  octet_acc;
    logic [1:0]  octet_idx;
    logic        octet_seen;
    logic [31:0] first_addr;
    logic [31:0] second_value;
    form_e       form;
    logic [31:0] rack_acc;
    status_e     err;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:        PH_START,
    octet_acc:    8'd0,
    octet_idx:    2'd0,
    octet_seen:   1'b0,
    first_addr:   32'd0,
    second_value: 32'd0,
    form:         FORM_PLAIN,
    rack_acc:     32'd0,
    err:          ST_OK
  };

endpackage

// ===== rtl/irlp_step.sv =====
// Combinational per-byte parser step: line state and one byte in, next line
// state and the line result out. Depends on irlp_pkg.
module irlp_step (
  input  irlp_pkg::line_state_t state_i,
  input  irlp_pkg::in_req_t     req_i,
  output irlp_pkg::line_state_t state_o,
  output irlp_pkg::out_rsp_t    rsp_o
);
  import irlp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] lo;
    logic [31:0] hi;
  } fin_t;

  line_state_t s;
  fin_t        fin;
  logic [7:0]  c;
  logic [3:0]  dig;
  logic [35:0] rack_next;
  status_e     st;

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic line_state_t commit_octet(line_state_t si);
    line_state_t r;
    r = si;
    if (r.form == FORM_PLAIN) begin
      r.first_addr = {r.first_addr[23:0], r.octet_acc};
    end else begin
      r.second_value = {r.second_value[23:0], r.octet_acc};
    end
    r.octet_acc  = 8'd0;
    r.octet_seen = 1'b0;
    return r;
  endfunction

  // one token character, not a blank and not NUL
  function automatic line_state_t net_char(line_state_t si, logic [7:0] b);
    line_state_t r;
    logic [11:0] v;
    r = si;
    v = ({4'd0, si.octet_acc} << 3) + ({4'd0, si.octet_acc} << 1)
        + {8'd0, 4'(b - CH_ZERO)};
    if (si.err == ST_BADNET) begin
      r = si;
    end else if (si.form == FORM_STAR) begin
      r.err = ST_BADNET;
    end else if (is_digit(b)) begin
      if (v > {4'd0, OCTET_MAX}) begin
        r.err = ST_BADNET;
      end else begin
        r.octet_acc  = v[7:0];
        r.octet_seen = 1'b1;
      end
    end else if (!si.octet_seen) begin
      r.err = ST_BADNET;
    end else if (si.octet_idx != 2'd3) begin
      if (b != CH_DOT) begin
        r.err = ST_BADNET;
      end else begin
        r = commit_octet(si);
        r.octet_idx = si.octet_idx + 2'd1;
      end
    end else begin
      r = commit_octet(si);
      if (si.form == FORM_PLAIN && (b == CH_SLASH || b == CH_DASH)) begin
        r.form         = (b == CH_SLASH) ? FORM_SLASH : FORM_DASH;
        r.octet_idx    = 2'd0;
        r.second_value = 32'd0;
      end else begin
        r.err = ST_BADNET;
      end
    end
    return r;
  endfunction

  // token closed by a blank: resolve the address range
  function automatic fin_t net_finish(line_state_t si);
    fin_t        f;
    logic [31:0] mask;
    logic [31:0] low;
    logic [4:0]  sh;
    f.ok = 1'b0;
    f.lo = si.first_addr;
    f.hi = si.second_value;
    sh   = 5'(6'd32 - si.octet_acc[5:0]);
    mask = 32'd0;
    low  = 32'd0;
    if (si.err == ST_BADNET) begin
      f.ok = 1'b0;
    end else if (si.form == FORM_STAR) begin
      f.ok = 1'b1;
      f.lo = 32'd0;
      f.hi = ALL_ONES;
    end else if (!si.octet_seen) begin
      f.ok = 1'b0;
    end else if (si.form == FORM_SLASH && si.octet_idx == 2'd0 &&
                 si.octet_acc <= PREFIX_MAX) begin
      // prefix length; /0 means every address
      mask = (si.octet_acc == 8'd0) ? 32'd0 : (ALL_ONES << sh);
      low  = si.first_addr & mask;
      f.ok = 1'b1;
      f.lo = low;
      f.hi = low | ~mask;
    end else if (si.octet_idx != 2'd3) begin
      f.ok = 1'b0;
    end else if (si.form == FORM_PLAIN) begin
      f.ok = 1'b1;
      f.lo = {si.first_addr[23:0], si.octet_acc};
      f.hi = {si.first_addr[23:0], si.octet_acc};
    end else if (si.form == FORM_SLASH) begin
      mask = {si.second_value[23:0], si.octet_acc};
      low  = si.first_addr & mask;
      f.ok = 1'b1;
      f.lo = low;
      f.hi = low | ~mask;
    end else begin
      f.ok = 1'b1;
      f.hi = {si.second_value[23:0], si.octet_acc};
    end
    return f;
  endfunction

  assign c   = req_i.text_byte;
  assign dig = 4'(c - CH_ZERO);
  assign fin = net_finish(state_i);
  assign rack_next = ({4'd0, state_i.rack_acc} << 3) + ({4'd0, state_i.rack_acc} << 1)
                     + {32'd0, dig};

  always_comb begin
    s = state_i;
    case (state_i.phase)
      PH_START, PH_LEAD: begin
        if (state_i.phase == PH_START && c == CH_HASH) begin
          s.phase = PH_DONE;
          s.err   = ST_BLANK;
        end else if (is_blank(c)) begin
          s.phase = PH_LEAD;
        end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
          s.phase = PH_DONE;
          s.err   = ST_BLANK;
        end else if (c == CH_STAR) begin
          s.phase = PH_TOKEN;
          s.form  = FORM_STAR;
        end else begin
          s       = net_char(state_i, c);
          s.phase = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (c == CH_NUL) begin
          s.phase = PH_DONE;
          s.err   = ST_INCOMPLETE;
        end else if (is_blank(c)) begin
          if (fin.ok) begin
            s.first_addr   = fin.lo;
            s.second_value = fin.hi;
            s.phase        = PH_MID;
          end else begin
            s.phase = PH_DONE;
            s.err   = ST_BADNET;
          end
        end else begin
          s = net_char(state_i, c);
        end
      end
      PH_MID: begin
        if (is_digit(c)) begin
          s.rack_acc = {28'd0, dig};
          s.phase    = PH_RACK;
        end else if (!is_blank(c)) begin
          s.phase = PH_DONE;
          s.err   = ST_BADRACK;
        end
      end
      PH_RACK, PH_TAIL: begin
        if (state_i.phase == PH_RACK && is_digit(c)) begin
          // saturate at 2^32-1
          s.rack_acc = (rack_next[35:32] != 4'd0) ? ALL_ONES : rack_next[31:0];
        end else if (is_blank(c)) begin
          s.phase = PH_TAIL;
        end else if (c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_HASH) begin
          s.phase = PH_DONE;
          s.err   = ST_OK;
        end else begin
          s.phase = PH_DONE;
          s.err   = ST_GARBAGE;
        end
      end
      default: begin
        s = state_i;
      end
    endcase

    case (s.phase)
      PH_DONE:           st = s.err;
      PH_START, PH_LEAD: st = ST_BLANK;
      PH_TOKEN:          st = ST_INCOMPLETE;
      PH_MID:            st = ST_BADRACK;
      default:           st = ST_OK;
    endcase

    rsp_o.status = st;
    if (st == ST_OK) begin
      rsp_o.range_low   = s.first_addr;
      rsp_o.range_high  = s.second_value;
      rsp_o.rack_number = s.rack_acc;
    end else begin
      rsp_o.range_low   = 32'd0;
      rsp_o.range_high  = 32'd0;
      rsp_o.rack_number = 32'd0;
    end

    state_o = req_i.line_end ? LINE_CLEAR : s;
  end

endmodule

// ===== rtl/ipv4_range_rule_line_parser.sv =====
// IPv4 range rule line parser top level: input register, line state register
// and result register around irlp_step. Depends on irlp_pkg and irlp_step.
//
// Parses one text line per request stream, one byte per request, and returns
// one result (status, address range, rack id) for the byte flagged line_end.
// A byte request is taken in every cycle unless the input side stalls; the byte
// is registered in the input register, then parsed in a single pass through
// irlp_step, which updates the line state and, for a line-end byte, loads the
// result register. The input side stalls only when a line-end byte is waiting
// in the input register while the result register still holds an unread
// result.
module ipv4_range_rule_line_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  irlp_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output irlp_pkg::out_rsp_t   out_rsp_o
);
  import irlp_pkg::*;

  in_req_t     in_q;
  logic        in_valid_q;
  logic        in_valid_d;
  line_state_t state_q;
  line_state_t state_d;
  out_rsp_t    out_q;
  out_rsp_t    step_rsp;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        advance;
  logic        in_accept;

  irlp_step u_step (
    .state_i (state_q),
    .req_i   (in_q),
    .state_o (state_d),
    .rsp_o   (step_rsp)
  );

  // a line-end byte needs room in the result register
  assign advance    = in_valid_q && (!in_q.line_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign in_valid_d = in_accept || (in_valid_q && !advance);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_q.line_end) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= LINE_CLEAR;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
    if (advance && in_q.line_end) begin
      out_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== test/ipv4_range_rule_line_parser_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ipv4_range_rule_line_parser: feeds text lines byte by byte
// and compares each line's status, address range and rack id with a local line parser.
// Depends on irlp_pkg and the parser RTL.
module ipv4_range_rule_line_parser_tb;
  import irlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_rsp_t out_rsp_o;

  ipv4_range_rule_line_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  in_req_t    byte_feed[$];
  out_rsp_t   rule_results_q[$];
  logic [7:0] line_buf[$];
  int         items_added   = 0;
  int         mismatches    = 0;
  int         send_idle_pct = 33;
  int         recv_idle_pct = 74;
  logic       long_hold     = 1'b0;
  int         hold_cnt;
  int         idle_cycles;
  out_rsp_t   want_rsp;

  // line parser state
  phase_e      ln_phase;
  logic [7:0]  ln_acc;
  logic [1:0]  ln_idx;
  logic        ln_seen;
  logic [31:0] ln_first;
  logic [31:0] ln_second;
  form_e       ln_form;
  logic [31:0] ln_rack;
  status_e     ln_err;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_line();
    ln_phase  = PH_START;
    ln_acc    = '0;
    ln_idx    = '0;
    ln_seen   = 1'b0;
    ln_first  = '0;
    ln_second = '0;
    ln_form   = FORM_PLAIN;
    ln_rack   = '0;
    ln_err    = ST_OK;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void close_line(status_e st);
    ln_err   = st;
    ln_phase = PH_DONE;
  endfunction

  function automatic void commit_octet();
    if (ln_form == FORM_PLAIN) ln_first = {ln_first[23:0], ln_acc};
    else ln_second = {ln_second[23:0], ln_acc};
    ln_acc  = '0;
    ln_seen = 1'b0;
  endfunction

  // one non-blank, non-NUL character inside the network token
  function automatic void token_char(logic [7:0] c);
    int unsigned v;
    if (ln_err == ST_BADNET) return;
    if (ln_form == FORM_STAR) begin
      ln_err = ST_BADNET;
      return;
    end
    if (is_digit(c)) begin
      v = 32'(ln_acc) * 32'd10 + 32'(c) - 32'(CH_ZERO);
      if (v > OCTET_MAX) ln_err = ST_BADNET;
      else begin
        ln_acc  = v[7:0];
        ln_seen = 1'b1;
      end
      return;
    end
    if (!ln_seen) begin
      ln_err = ST_BADNET;
      return;
    end
    if (ln_idx < 2'd3) begin
      if (c != CH_DOT) begin
        ln_err = ST_BADNET;
        return;
      end
      commit_octet();
      ln_idx++;
      return;
    end
    commit_octet();
    if (ln_form == FORM_PLAIN && (c == CH_SLASH || c == CH_DASH)) begin
      ln_form   = (c == CH_SLASH) ? FORM_SLASH : FORM_DASH;
      ln_idx    = '0;
      ln_second = '0;
    end else begin
      ln_err = ST_BADNET;
    end
  endfunction

  // advance the line state by one accepted request; a line-end byte yields a result
  function automatic void parse_byte(in_req_t r);
    logic [7:0]  c;
    logic [31:0] mask;
    logic [63:0] wide;
    logic        good;
    out_rsp_t    res;
    c = r.text_byte;
    if (ln_phase == PH_START) begin
      if (c == CH_HASH) close_line(ST_BLANK);
      else ln_phase = PH_LEAD;
    end
    if (ln_phase == PH_RACK && !is_digit(c)) ln_phase = PH_TAIL;
    case (ln_phase)
      PH_LEAD: begin
        if (c == CH_NUL || c == CH_CR || c == CH_LF) close_line(ST_BLANK);
        else if (!is_blank(c)) begin
          ln_phase = PH_TOKEN;
          if (c == CH_STAR) ln_form = FORM_STAR;
          else token_char(c);
        end
      end
      PH_TOKEN: begin
        if (c == CH_NUL) close_line(ST_INCOMPLETE);
        else if (is_blank(c)) begin
          // token closed: resolve it into a from/to pair
          good = 1'b1;
          if (ln_err == ST_BADNET) good = 1'b0;
          else if (ln_form == FORM_STAR) begin
            ln_first  = '0;
            ln_second = ALL_ONES;
          end else if (!ln_seen) good = 1'b0;
          else if (ln_form == FORM_SLASH && ln_idx == 2'd0 && ln_acc <= PREFIX_MAX) begin
            mask      = (ln_acc == 8'd0) ? 32'd0 : ALL_ONES << (PREFIX_MAX - ln_acc);
            ln_first  = ln_first & mask;
            ln_second = ln_first | ~mask;
          end else if (ln_idx != 2'd3) good = 1'b0;
          else if (ln_form == FORM_PLAIN) begin
            ln_first  = {ln_first[23:0], ln_acc};
            ln_second = ln_first;
          end else if (ln_form == FORM_SLASH) begin
            mask      = {ln_second[23:0], ln_acc};
            ln_first  = ln_first & mask;
            ln_second = ln_first | ~mask;
          end else begin
            ln_second = {ln_second[23:0], ln_acc};
          end
          if (good) ln_phase = PH_MID;
          else close_line(ST_BADNET);
        end else begin
          token_char(c);
        end
      end
      PH_MID: begin
        if (is_digit(c)) begin
          ln_rack  = 32'(c - CH_ZERO);
          ln_phase = PH_RACK;
        end else if (!is_blank(c)) begin
          close_line(ST_BADRACK);
        end
      end
      PH_RACK: begin
        wide    = 64'(ln_rack) * 64'd10 + 64'(c - CH_ZERO);
        ln_rack = (wide > 64'(ALL_ONES)) ? ALL_ONES : wide[31:0];
      end
      PH_TAIL: begin
        if (c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_HASH) close_line(ST_OK);
        else if (!is_blank(c)) close_line(ST_GARBAGE);
      end
      default: ;
    endcase
    if (!r.line_end) return;
    res = '0;
    case (ln_phase)
      PH_DONE:           res.status = ln_err;
      PH_START, PH_LEAD: res.status = ST_BLANK;
      PH_TOKEN:          res.status = ST_INCOMPLETE;
      PH_MID:            res.status = ST_BADRACK;
      default:           res.status = ST_OK;
    endcase
    if (res.status == ST_OK) begin
      res.range_low   = ln_first;
      res.range_high  = ln_second;
      res.rack_number = ln_rack;
    end
    rule_results_q.push_back(res);
    clear_line();
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_num(int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // dotted quad, now and then with a leading zero or an octet out of range
  task automatic add_quad(logic [31:0] a);
    int unsigned v;
    for (int i = 3; i >= 0; i--) begin
      v = a[8*i +: 8];
      if ($urandom_range(0, 39) == 0) v = $urandom_range(256, 999);
      if ($urandom_range(0, 19) == 0) line_buf.push_back(CH_ZERO);
      add_num(v);
      if (i != 0) line_buf.push_back(CH_DOT);
    end
  endtask

  task automatic emit_line();
    if (line_buf.size() == 0) line_buf.push_back(CH_LF);
    foreach (line_buf[i])
      byte_feed.push_back(in_req_t'{text_byte: line_buf[i], line_end: i == line_buf.size() - 1});
    items_added += line_buf.size();
    line_buf.delete();
  endtask

  task automatic text_line(string s);
    add_text(s);
    emit_line();
  endtask

  // mostly well-formed rules with random content, plus comments, blanks and noise
  task automatic fill_random(int count);
    int          stop;
    int          kind;
    int          n;
    int          pos;
    logic [31:0] mask;
    stop = items_added + count;
    while (items_added < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        n = $urandom_range(1, 10);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 12) begin
        line_buf.push_back(CH_HASH);
        repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 15) begin
        add_blanks(0, 3);
        case ($urandom_range(0, 3))
          0: line_buf.push_back(CH_CR);
          1: line_buf.push_back(CH_LF);
          2: line_buf.push_back(CH_NUL);
          default: ;
        endcase
      end else begin
        add_blanks(0, 2);
        case ($urandom_range(0, 9))
          0: line_buf.push_back(CH_STAR);
          1, 2, 3: add_quad($urandom);
          4, 5: begin
            add_quad($urandom);
            line_buf.push_back(CH_SLASH);
            add_num($urandom_range(0, 34));
          end
          6, 7: begin
            add_quad($urandom);
            line_buf.push_back(CH_SLASH);
            mask = $urandom_range(0, 1) ? ALL_ONES << $urandom_range(0, 32) : $urandom;
            add_quad(mask);
          end
          default: begin
            add_quad($urandom);
            line_buf.push_back(CH_DASH);
            add_quad($urandom);
          end
        endcase
        if ($urandom_range(0, 29) != 0) begin
          add_blanks(1, 3);
          case ($urandom_range(0, 9))
            0: repeat ($urandom_range(10, 14)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            1: add_num($urandom);
            default: add_num($urandom_range(0, 99999));
          endcase
          case ($urandom_range(0, 9))
            3: add_blanks(1, 2);
            4: begin
              add_blanks(0, 2);
              line_buf.push_back(CH_HASH);
              repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(32, 126)));
            end
            5: line_buf.push_back(CH_CR);
            6: line_buf.push_back(CH_LF);
            7: begin
              line_buf.push_back(CH_CR);
              line_buf.push_back(CH_LF);
            end
            8: line_buf.push_back(8'($urandom_range(0, 255)));
            9: begin
              line_buf.push_back(CH_NUL);
              repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
          endcase
        end
        if ($urandom_range(0, 9) == 0) begin
          pos = $urandom_range(0, line_buf.size() - 1);
          line_buf[pos] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 19) == 0) begin
          n = $urandom_range(1, line_buf.size());
          while (line_buf.size() > n) void'(line_buf.pop_back());
        end
      end
      emit_line();
    end
  endtask

  task automatic drain();
    while (byte_feed.size() != 0 || in_valid || rule_results_q.size() != 0) @(negedge clk_i);
  endtask

  // byte request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      if (in_valid && in_ready_o) parse_byte(in_req);
      if (!in_valid || in_ready_o) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side ready, with one long hold-off once long_hold is raised
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (rule_results_q.size() == 0) begin
        report_mismatch("result with no line pending");
      end else begin
        want_rsp = rule_results_q.pop_front();
        if (out_rsp_o.status !== want_rsp.status)
          report_mismatch($sformatf("status %0d, want %0d", out_rsp_o.status, want_rsp.status));
        if (out_rsp_o.range_low !== want_rsp.range_low)
          report_mismatch($sformatf("range_low %h, want %h",
                                    out_rsp_o.range_low, want_rsp.range_low));
        if (out_rsp_o.range_high !== want_rsp.range_high)
          report_mismatch($sformatf("range_high %h, want %h",
                                    out_rsp_o.range_high, want_rsp.range_high));
        if (out_rsp_o.rack_number !== want_rsp.rack_number)
          report_mismatch($sformatf("rack_number %0d, want %0d",
                                    out_rsp_o.rack_number, want_rsp.rack_number));
      end
    end
  end

  // watchdog: ends the run once nothing has been accepted for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_line();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    text_line("# comment line");
    text_line("   \t ");
    text_line("* 1");
    text_line("0.0.0.0 0");
    text_line("255.255.255.255 4294967295");
    text_line("10.1.2.3/0 7");
    text_line("10.1.2.3/32 4294967296");
    text_line("192.168.77.9/24 12#rack row");
    add_text("10.20.30.40/255.255.0.0\t99");
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
    emit_line();
    text_line("\t9.8.7.6-1.2.3.4  0012 ");
    text_line("256.1.1.1 5");
    text_line("1.2.3.400");
    text_line("1.2.3.4  ");
    text_line("1.2.3.4 x");
    text_line("1.2.3.4 99999999999");
    text_line("1.2.3.4 12x");
    text_line("*5 1");
    text_line("1.2.3 4");
    text_line("1.2.3.4/33 1");
    add_text("1.2");
    line_buf.push_back(CH_CR);
    add_text("3.4 5");
    emit_line();
    add_text("1.2.3.4 5");
    line_buf.push_back(CH_NUL);
    add_text("junk");
    emit_line();
    line_buf.push_back(CH_NUL);
    add_text("x");
    emit_line();
    add_text("4.3.2.1");
    line_buf.push_back(CH_NUL);
    emit_line();

    fill_random(700);
    drain();

    send_idle_pct = 74;
    recv_idle_pct = 33;
    fill_random(650);
    drain();

    // no idling; the receiver holds off long enough to back the parser up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold     = 1'b1;
    fill_random(650);
    drain();

    repeat (12) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/irlp_pkg.sv
rtl/irlp_step.sv
rtl/ipv4_range_rule_line_parser.sv
test/ipv4_range_rule_line_parser_tb.sv
